@@ hdl/fpd_pkg.sv @@
// Package for the flight phase detector: sizes, codes and control structs.
`timescale 1ns / 1ps

package fpd_pkg;

    localparam int WINDOW        = 16;
    localparam int APOGEE_WINDOW = 64;

    localparam int SAMPLE_W = 16;
    localparam int APOGEE_W = 15;
    localparam int PHASE_W  = 2;

    localparam int WPOS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int APOS_W   = (APOGEE_WINDOW > 1) ? $clog2(APOGEE_WINDOW) : 1;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int SQ_SUM_W = SQ_W + $clog2(WINDOW);
    localparam int CMP_W    = 32;
    localparam int SPREAD_W = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BURN_ALT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT   = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] BURNOUT_RESET = 16'sd500;
    localparam logic signed [SAMPLE_W-1:0] DESCENT_RESET = 16'sd0;
    localparam logic [SAMPLE_W-1:0]        SPREAD_RESET  = 16'd2;

    typedef enum logic [PHASE_W-1:0] {
        PH_LANDED  = 2'd0,
        PH_COAST   = 2'd1,
        PH_DESCEND = 2'd2
    } phase_t;

    typedef struct packed {
        logic   in_open;
        logic   load;
        logic   square;
        logic   scan_start;
        logic   scan_step;
        logic   latch_apogee;
        logic   phase_we;
        phase_t phase_val;
        logic   emit;
    } fpd_cmd_t;

    typedef struct packed {
        logic   in_fire;
        logic   alt_above;
        logic   vel_below;
        logic   vel_above;
        logic   spread_below;
        logic   scan_last;
        logic   out_free;
        phase_t phase;
    } fpd_status_t;

endpackage

@@ hdl/fpd_if.sv @@
// Item channel interfaces for the flight phase detector.
`timescale 1ns / 1ps

interface fpd_in_if;
    import fpd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] altitude;
    logic signed [SAMPLE_W-1:0] velocity;

    modport source  (output valid, altitude, velocity, input ready);
    modport sink    (input valid, altitude, velocity, output ready);
    modport monitor (input valid, ready, altitude, velocity);
endinterface

interface fpd_out_if;
    import fpd_pkg::*;
    logic                valid;
    logic                ready;
    logic [PHASE_W-1:0]  phase;
    logic [APOGEE_W-1:0] apogee;

    modport source  (output valid, phase, apogee, input ready);
    modport sink    (input valid, phase, apogee, output ready);
    modport monitor (input valid, ready, phase, apogee);
endinterface

@@ hdl/fpd_datapath.sv @@
// Datapath: windows, running sums, threshold compares, apogee scan, output register.
`timescale 1ns / 1ps

module fpd_datapath
    import fpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fpd_in_if.sink                in_ch,
    fpd_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  fpd_cmd_t              cmd,
    output fpd_status_t           status
);

    localparam logic signed [SPREAD_W-1:0] WIN_S  = SPREAD_W'(WINDOW);
    localparam logic signed [SPREAD_W-1:0] WIN_SQ = SPREAD_W'(WINDOW * WINDOW);
    localparam logic signed [CMP_W-1:0]    WIN_C  = CMP_W'(WINDOW);

    // configuration
    logic signed [SAMPLE_W-1:0] burnout_reg;
    logic signed [SAMPLE_W-1:0] descent_reg;
    logic [SAMPLE_W-1:0]        spread_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burnout_reg <= BURNOUT_RESET;
            descent_reg <= DESCENT_RESET;
            spread_reg  <= SPREAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BURN_ALT:       burnout_reg <= $signed(cfg_wdata[SAMPLE_W-1:0]);
                CFG_DESCENT_LIMIT:  descent_reg <= $signed(cfg_wdata[SAMPLE_W-1:0]);
                CFG_SPREAD_LIMIT:   spread_reg  <= cfg_wdata[SAMPLE_W-1:0];
                default:            ;
            endcase
        end
    end

    // captured item
    logic signed [SAMPLE_W-1:0] alt_reg;
    logic signed [SAMPLE_W-1:0] vel_reg;

    assign in_ch.ready    = cmd.in_open;
    assign status.in_fire = in_ch.valid && cmd.in_open;

    always_ff @(posedge clk)
    begin
        if (status.in_fire)
        begin
            alt_reg <= in_ch.altitude;
            vel_reg <= in_ch.velocity;
        end
    end

    // short windows and running sums
    logic signed [SAMPLE_W-1:0] alt_win_reg [WINDOW];
    logic signed [SAMPLE_W-1:0] vel_win_reg [WINDOW];
    logic [WPOS_W-1:0]          wpos_reg;
    logic [APOS_W-1:0]          apos_reg;
    logic signed [SUM_W-1:0]    alt_sum_reg;
    logic signed [SUM_W-1:0]    vel_sum_reg;
    logic [SQ_W-1:0]            sq_new_reg;
    logic [SQ_W-1:0]            sq_old_reg;
    logic [SQ_SUM_W-1:0]        sq_sum_reg;
    logic signed [2*SUM_W-1:0]  ssq_reg;
    logic [2*SAMPLE_W-1:0]      limsq_reg;

    logic signed [SAMPLE_W-1:0]   old_alt;
    logic signed [SAMPLE_W-1:0]   old_vel;
    logic signed [2*SAMPLE_W-1:0] sq_new_full;
    logic signed [2*SAMPLE_W-1:0] sq_old_full;

    assign old_alt     = alt_win_reg[wpos_reg];
    assign old_vel     = vel_win_reg[wpos_reg];
    assign sq_new_full = alt_reg * alt_reg;
    assign sq_old_full = old_alt * old_alt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                alt_win_reg[i] <= '0;
                vel_win_reg[i] <= '0;
            end
            alt_sum_reg <= '0;
            vel_sum_reg <= '0;
            sq_sum_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                alt_win_reg[wpos_reg] <= alt_reg;
                vel_win_reg[wpos_reg] <= vel_reg;
                alt_sum_reg <= alt_sum_reg + SUM_W'(alt_reg) - SUM_W'(old_alt);
                vel_sum_reg <= vel_sum_reg + SUM_W'(vel_reg) - SUM_W'(old_vel);
            end
            if (cmd.square)
                sq_sum_reg <= sq_sum_reg + SQ_SUM_W'(sq_new_reg) - SQ_SUM_W'(sq_old_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sq_new_reg <= sq_new_full[SQ_W-1:0];
            sq_old_reg <= sq_old_full[SQ_W-1:0];
        end
        if (cmd.square)
        begin
            ssq_reg   <= alt_sum_reg * alt_sum_reg;
            limsq_reg <= spread_reg * spread_reg;
        end
    end

    // threshold compares
    logic signed [CMP_W-1:0]    burn_scaled;
    logic signed [CMP_W-1:0]    desc_scaled;
    logic signed [CMP_W-1:0]    neg_desc_scaled;
    logic signed [SPREAD_W-1:0] spread_lhs;
    logic signed [SPREAD_W-1:0] spread_rhs;

    assign burn_scaled     = CMP_W'(burnout_reg) * WIN_C;
    assign desc_scaled     = CMP_W'(descent_reg) * WIN_C;
    assign neg_desc_scaled = -desc_scaled;
    assign spread_lhs      = $signed({{(SPREAD_W-SQ_SUM_W){1'b0}}, sq_sum_reg}) * WIN_S
                           - SPREAD_W'(ssq_reg);
    assign spread_rhs      = $signed({{(SPREAD_W-2*SAMPLE_W){1'b0}}, limsq_reg}) * WIN_SQ;

    assign status.alt_above    = CMP_W'(alt_sum_reg) > burn_scaled;
    assign status.vel_below    = CMP_W'(vel_sum_reg) < desc_scaled;
    assign status.vel_above    = CMP_W'(vel_sum_reg) > neg_desc_scaled;
    assign status.spread_below = spread_lhs < spread_rhs;

    // long altitude window memory and apogee scan
    logic signed [SAMPLE_W-1:0] apo_mem [APOGEE_WINDOW];
    logic [APOGEE_WINDOW-1:0]   apo_valid_reg;
    logic [APOS_W-1:0]          scan_addr_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_ok_reg;
    logic                       pend_reg;
    logic signed [SAMPLE_W-1:0] best_reg;
    logic signed [SAMPLE_W-1:0] peak_cand;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            apo_mem[apos_reg] <= alt_reg;
        if (cmd.scan_step)
            rd_data_reg <= apo_mem[scan_addr_reg];
    end

    assign status.scan_last = scan_addr_reg == APOS_W'(APOGEE_WINDOW - 1);
    assign peak_cand = (pend_reg && rd_ok_reg && (rd_data_reg > best_reg)) ? rd_data_reg
                                                                           : best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apo_valid_reg <= '0;
            scan_addr_reg <= '0;
            rd_ok_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            best_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
                apo_valid_reg[apos_reg] <= 1'b1;
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
                pend_reg      <= 1'b0;
                best_reg      <= '0;
            end
            else
            begin
                pend_reg <= cmd.scan_step;
                best_reg <= peak_cand;
                if (cmd.scan_step)
                begin
                    rd_ok_reg     <= apo_valid_reg[scan_addr_reg];
                    scan_addr_reg <= status.scan_last ? '0 : scan_addr_reg + 1'b1;
                end
            end
        end
    end

    // phase, apogee, positions, output register
    phase_t              phase_reg;
    logic [APOGEE_W-1:0] apogee_reg;
    logic                out_valid_reg;
    logic [PHASE_W-1:0]  out_phase_reg;
    logic [APOGEE_W-1:0] out_apogee_reg;

    assign status.phase    = phase_reg;
    assign status.out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LANDED;
            apogee_reg    <= '0;
            wpos_reg      <= '0;
            apos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.phase_we)
                phase_reg <= cmd.phase_val;
            if (cmd.latch_apogee)
                apogee_reg <= peak_cand[APOGEE_W-1:0];
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                wpos_reg <= (wpos_reg == WPOS_W'(WINDOW - 1)) ? '0 : wpos_reg + 1'b1;
                apos_reg <= (apos_reg == APOS_W'(APOGEE_WINDOW - 1)) ? '0 : apos_reg + 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_phase_reg  <= phase_reg;
            out_apogee_reg <= apogee_reg;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.phase  = out_phase_reg;
    assign out_ch.apogee = out_apogee_reg;

endmodule

@@ hdl/fpd_controller.sv @@
// Controller: sequences load, square, decide, apogee scan and result issue.
`timescale 1ns / 1ps

module fpd_controller
    import fpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fpd_status_t status,
    output fpd_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_LOAD     = 7'b0000010,
        S_SQUARE   = 7'b0000100,
        S_EVAL     = 7'b0001000,
        S_SCAN     = 7'b0010000,
        S_SCAN_END = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_open = 1'b1;
                if (status.in_fire)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_EMIT;
                unique case (status.phase)
                    PH_COAST:
                    begin
                        if (status.vel_below)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    PH_DESCEND:
                    begin
                        priority if (status.vel_above)
                        begin
                            cmd.phase_we  = 1'b1;
                            cmd.phase_val = PH_COAST;
                        end
                        else if (status.spread_below)
                        begin
                            cmd.phase_we  = 1'b1;
                            cmd.phase_val = PH_LANDED;
                        end
                    end
                    default:
                    begin
                        cmd.phase_we  = 1'b1;
                        cmd.phase_val = status.alt_above ? PH_COAST : PH_LANDED;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = S_SCAN_END;
            end
            S_SCAN_END:
            begin
                cmd.latch_apogee = 1'b1;
                cmd.phase_we     = 1'b1;
                cmd.phase_val    = PH_DESCEND;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

@@ hdl/flight_phase_detector_core.sv @@
// Top level of the flight phase detector.
// One item (altitude, velocity) gives one result (phase, apogee). An accepted
// item passes the load, square and evaluate states, then the emit state writes
// its result to the output register once that register is free or being taken;
// on the item that detects descent the 64-entry long altitude window is scanned
// through its single memory read port between evaluate and emit. A new item is
// accepted once the previous result is in the output register, even while that
// result waits to be taken. No clearing pass after reset.
`timescale 1ns / 1ps

module flight_phase_detector_core
    import fpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fpd_in_if.sink                in_ch,
    fpd_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    fpd_cmd_t    cmd;
    fpd_status_t status;

    fpd_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    fpd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ hdl/fpd_checker.sv @@
// Port-level checker for the flight phase detector, bound to the top level.
`timescale 1ns / 1ps

module fpd_checker
    import fpd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [PHASE_W-1:0]  out_phase,
    input logic [APOGEE_W-1:0] out_apogee
);

    localparam logic [PHASE_W-1:0] PH_W3 = 2'd3;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_phase) && $stable(out_apogee))
        else $error("stalled result changed");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_phase != PH_W3)
        else $error("phase code 3 on output");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in work");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result issued too early");

endmodule

bind flight_phase_detector_core fpd_checker u_fpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_phase  (out_ch.phase),
    .out_apogee (out_ch.apogee)
);
